// ----- rtl/core/bsoe_pkg.sv -----
// shared types and constants of the bit set operation engine
// no dependencies

package bsoe_pkg;

    localparam int DEF_MAX_BITS    = 256;
    localparam int DEF_NUM_VECTORS = 16;

    localparam int WORD_W     = 64;
    localparam int CFG_W      = 9;
    localparam int VALUE_W    = 9;
    localparam int ACTION_W   = 4;
    localparam int VEC_SEL_W  = 4;
    localparam int INDEX_W    = 8;

    localparam logic [CFG_W-1:0] VALID_BITS_RESET = 9'd256;

    typedef enum logic [ACTION_W-1:0] {
        ACT_CLEAR      = 4'd0,
        ACT_COPY       = 4'd1,
        ACT_SET        = 4'd2,
        ACT_TEST       = 4'd3,
        ACT_OR         = 4'd4,
        ACT_AND        = 4'd5,
        ACT_NOT        = 4'd6,
        ACT_EQUAL      = 4'd7,
        ACT_INTERSECTS = 4'd8,
        ACT_EMPTY      = 4'd9,
        ACT_FULL       = 4'd10,
        ACT_COUNT      = 4'd11,
        ACT_FIRST      = 4'd12,
        ACT_NEXT       = 4'd13
    } action_t;

    typedef enum logic [1:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_RUN,
        ST_DRAIN
    } state_t;

endpackage

// ----- rtl/core/bit_set_operation_engine.sv -----
// bit set operation engine, top level
// depends on bsoe_pkg and bsoe_ram
//
// usage:
//   command channel: an item (action, first_vector, second_vector, bit_index)
//   transfers at a rising edge with start high and busy low.
//   result channel: done is high for exactly one cycle with flag, value and
//   error; the receiver takes it in that cycle and cannot stall it.
//   configuration: cfg_we with cfg_wdata writes valid_bits at any edge; busy
//   goes high at once and stays high while a trim pass clears every stored
//   bit at or above the new length.
// operation:
//   the vectors live in one 64-bit wide memory, one word per cycle, with
//   VEC_WORDS = ceil(MAX_BITS/64) words per vector. An item reads its words
//   in ST_RUN, each processed and written back in the registered stage
//   behind the read; ST_DRAIN ends the last write-back, then done appears.
//   No new item is taken before done; the next item is accepted at
//   the edge that ends the done cycle.
//   the trim pass after reset or a configuration write sweeps every word of
//   every vector; after reset it clears the whole memory.
//   valid_bits resets to 256.

module bit_set_operation_engine #(
    parameter int MAX_BITS    = bsoe_pkg::DEF_MAX_BITS,
    parameter int NUM_VECTORS = bsoe_pkg::DEF_NUM_VECTORS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [bsoe_pkg::ACTION_W-1:0]  action,
    input  logic [bsoe_pkg::VEC_SEL_W-1:0] first_vector,
    input  logic [bsoe_pkg::VEC_SEL_W-1:0] second_vector,
    input  logic [bsoe_pkg::INDEX_W-1:0]   bit_index,
    input  logic                           cfg_we,
    input  logic [bsoe_pkg::CFG_W-1:0]     cfg_wdata,
    output logic                           done,
    output logic                           flag,
    output logic [bsoe_pkg::VALUE_W-1:0]   value,
    output logic                           error
);

    import bsoe_pkg::*;

    localparam int VEC_WORDS = (MAX_BITS + WORD_W - 1) / WORD_W;
    localparam int DEPTH     = NUM_VECTORS * VEC_WORDS;
    localparam int AW        = $clog2(DEPTH);
    localparam int WCW       = (VEC_WORDS > 1) ? $clog2(VEC_WORDS) : 1;
    localparam int VNW       = $clog2(NUM_VECTORS);
    localparam int LW        = $clog2(MAX_BITS + 1);
    localparam int POS_W     = ((LW > VALUE_W) ? LW : VALUE_W) + 1;

    localparam logic [WORD_W-1:0] ONES = {WORD_W{1'b1}};

    state_t                state_reg,      state_next;
    logic [ACTION_W-1:0]   act_reg,        act_next;
    logic [INDEX_W-1:0]    idx_reg,        idx_next;
    logic [VNW-1:0]        a_vec_reg,      a_vec_next;
    logic [VNW-1:0]        b_vec_reg,      b_vec_next;
    logic [VNW-1:0]        sweep_vec_reg,  sweep_vec_next;
    logic [WCW-1:0]        word_cnt_reg,   word_cnt_next;
    logic [CFG_W-1:0]      valid_bits_reg, valid_bits_next;
    logic [POS_W-1:0]      trim_len_reg,   trim_len_next;
    logic                  proc_valid_reg, proc_valid_next;
    logic                  proc_sweep_reg, proc_sweep_next;
    logic                  proc_last_reg,  proc_last_next;
    logic [WCW-1:0]        proc_word_reg,  proc_word_next;
    logic [AW-1:0]         proc_addr_reg,  proc_addr_next;
    logic                  acc_flag_reg,   acc_flag_next;
    logic                  acc_found_reg,  acc_found_next;
    logic [POS_W-1:0]      acc_pos_reg,    acc_pos_next;
    logic [POS_W-1:0]      acc_count_reg,  acc_count_next;
    logic                  done_reg,       done_next;
    logic                  flag_reg,       flag_next;
    logic [VALUE_W-1:0]    value_reg,      value_next;
    logic                  error_reg,      error_next;

    logic                  accept;
    logic [VNW-1:0]        rd_vec;
    logic [AW-1:0]         raddr_a;
    logic [AW-1:0]         raddr_b;
    logic [WORD_W-1:0]     rdata_a;
    logic [WORD_W-1:0]     rdata_b;
    logic                  mem_we;
    logic [WORD_W-1:0]     mem_wdata;

    logic [POS_W-1:0]      cur_len;
    logic [POS_W-1:0]      new_len;
    logic [POS_W-1:0]      lo;
    logic [POS_W-1:0]      idx_ext;
    logic [WORD_W-1:0]     mask;
    logic [WORD_W-1:0]     gt_mask;
    logic [WORD_W-1:0]     search_word;
    logic [WORD_W-1:0]     item_word;
    logic                  item_we;
    logic                  contrib;
    logic                  and_type;
    logic                  idx_ok;
    logic                  hit_word;
    logic [5:0]            ffs;
    logic                  flag_acc_new;
    logic                  found_new;
    logic [POS_W-1:0]      pos_new;
    logic [POS_W-1:0]      count_new;
    logic                  last_word;
    logic                  sweep_active;

    function automatic logic [VNW-1:0] vec_mod(input logic [VEC_SEL_W-1:0] v);
        logic [VEC_SEL_W:0] r;
        r = {1'b0, v};
        for (int k = 0; k < 8; k++)
        begin
            if (int'(r) >= NUM_VECTORS)
            begin
                r = r - (VEC_SEL_W+1)'(NUM_VECTORS);
            end
        end
        return VNW'(r);
    endfunction

    function automatic logic [WORD_W-1:0] word_mask(input logic [POS_W-1:0] len,
                                                    input logic [POS_W-1:0] base);
        logic [POS_W-1:0] d;
        d = len - base;
        if (len >= base + POS_W'(WORD_W))
        begin
            return ONES;
        end
        else if (len <= base)
        begin
            return '0;
        end
        return ~(ONES << d[5:0]);
    endfunction

    bsoe_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .we      (mem_we),
        .waddr   (proc_addr_reg),
        .wdata   (mem_wdata),
        .raddr_a (raddr_a),
        .rdata_a (rdata_a),
        .raddr_b (raddr_b),
        .rdata_b (rdata_b)
    );

    assign busy    = (state_reg != ST_IDLE) || cfg_we;
    assign accept  = start && !busy;
    assign rd_vec  = (state_reg == ST_SWEEP) ? sweep_vec_reg : a_vec_reg;
    assign raddr_a = AW'(rd_vec) * AW'(VEC_WORDS) + AW'(word_cnt_reg);
    assign raddr_b = AW'(b_vec_reg) * AW'(VEC_WORDS) + AW'(word_cnt_reg);

    assign done  = done_reg;
    assign flag  = flag_reg;
    assign value = value_reg;
    assign error = error_reg;

    // word processing stage
    always_comb
    begin
        cur_len = (POS_W'(valid_bits_reg) > POS_W'(MAX_BITS)) ? POS_W'(MAX_BITS)
                                                              : POS_W'(valid_bits_reg);
        new_len = (POS_W'(cfg_wdata) > POS_W'(MAX_BITS)) ? POS_W'(MAX_BITS)
                                                         : POS_W'(cfg_wdata);
        lo       = POS_W'(proc_word_reg) << 6;
        idx_ext  = POS_W'(idx_reg);
        idx_ok   = idx_ext < cur_len;
        hit_word = (idx_ext >> 6) == POS_W'(proc_word_reg);
        mask     = word_mask(proc_sweep_reg ? trim_len_reg : cur_len, lo);

        if (idx_ext < lo)
        begin
            gt_mask = ONES;
        end
        else if (idx_ext >= lo + POS_W'(WORD_W - 1))
        begin
            gt_mask = '0;
        end
        else
        begin
            gt_mask = (ONES << idx_reg[5:0]) << 1;
        end

        search_word = rdata_a & mask;
        if (act_reg == ACT_NEXT)
        begin
            search_word = search_word & gt_mask;
        end

        ffs = '0;
        for (int j = WORD_W - 1; j >= 0; j--)
        begin
            if (search_word[j])
            begin
                ffs = 6'(j);
            end
        end

        item_word = rdata_a;
        item_we   = 1'b0;
        contrib   = 1'b0;
        and_type  = 1'b0;
        case (act_reg)
            ACT_CLEAR:
            begin
                item_word = '0;
                item_we   = 1'b1;
            end
            ACT_COPY:
            begin
                item_word = rdata_b & mask;
                item_we   = 1'b1;
            end
            ACT_SET:
            begin
                if (idx_ok && hit_word)
                begin
                    item_word = rdata_a | (WORD_W'(1) << idx_reg[5:0]);
                end
                item_we = 1'b1;
            end
            ACT_TEST:
            begin
                contrib = idx_ok && hit_word && rdata_a[idx_reg[5:0]];
            end
            ACT_OR:
            begin
                item_word = (rdata_a | rdata_b) & mask;
                item_we   = 1'b1;
            end
            ACT_AND:
            begin
                item_word = rdata_a & rdata_b & mask;
                item_we   = 1'b1;
            end
            ACT_NOT:
            begin
                item_word = ~rdata_a & mask;
                item_we   = 1'b1;
            end
            ACT_EQUAL:
            begin
                contrib  = ((rdata_a ^ rdata_b) & mask) == '0;
                and_type = 1'b1;
            end
            ACT_INTERSECTS:
            begin
                contrib = (rdata_a & rdata_b & mask) != '0;
            end
            ACT_EMPTY:
            begin
                contrib  = (rdata_a & mask) == '0;
                and_type = 1'b1;
            end
            ACT_FULL:
            begin
                contrib  = (rdata_a & mask) == mask;
                and_type = 1'b1;
            end
            default:
            begin
                item_word = rdata_a;
            end
        endcase

        flag_acc_new = and_type ? (acc_flag_reg && contrib) : (acc_flag_reg || contrib);
        found_new    = acc_found_reg || (search_word != '0);
        pos_new      = acc_found_reg ? acc_pos_reg : lo + POS_W'(ffs);
        count_new    = acc_count_reg + POS_W'($countones(rdata_a & mask));

        mem_we    = proc_valid_reg && (proc_sweep_reg || item_we);
        mem_wdata = proc_sweep_reg ? (rdata_a & mask) : item_word;
    end

    // control, accumulators and results
    always_comb
    begin
        state_next      = state_reg;
        act_next        = act_reg;
        idx_next        = idx_reg;
        a_vec_next      = a_vec_reg;
        b_vec_next      = b_vec_reg;
        sweep_vec_next  = sweep_vec_reg;
        word_cnt_next   = word_cnt_reg;
        valid_bits_next = valid_bits_reg;
        trim_len_next   = trim_len_reg;
        proc_valid_next = 1'b0;
        proc_sweep_next = (state_reg == ST_SWEEP);
        proc_last_next  = 1'b0;
        proc_word_next  = word_cnt_reg;
        proc_addr_next  = raddr_a;
        acc_flag_next   = acc_flag_reg;
        acc_found_next  = acc_found_reg;
        acc_pos_next    = acc_pos_reg;
        acc_count_next  = acc_count_reg;
        done_next       = 1'b0;
        flag_next       = flag_reg;
        value_next      = value_reg;
        error_next      = error_reg;

        last_word    = word_cnt_reg == WCW'(VEC_WORDS - 1);
        sweep_active = (state_reg == ST_SWEEP) || ((state_reg == ST_DRAIN) && proc_sweep_reg);

        case (state_reg)
            ST_SWEEP:
            begin
                proc_valid_next = 1'b1;
                if (last_word)
                begin
                    word_cnt_next = '0;
                    if (sweep_vec_reg == VNW'(NUM_VECTORS - 1))
                    begin
                        proc_last_next = 1'b1;
                        state_next     = ST_DRAIN;
                    end
                    else
                    begin
                        sweep_vec_next = sweep_vec_reg + 1'b1;
                    end
                end
                else
                begin
                    word_cnt_next = word_cnt_reg + 1'b1;
                end
            end
            ST_RUN:
            begin
                proc_valid_next = 1'b1;
                if (last_word)
                begin
                    proc_last_next = 1'b1;
                    word_cnt_next  = '0;
                    state_next     = ST_DRAIN;
                end
                else
                begin
                    word_cnt_next = word_cnt_reg + 1'b1;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    act_next       = action;
                    idx_next       = bit_index;
                    a_vec_next     = vec_mod(first_vector);
                    b_vec_next     = vec_mod(second_vector);
                    word_cnt_next  = '0;
                    acc_flag_next  = action inside {ACT_EQUAL, ACT_EMPTY, ACT_FULL};
                    acc_found_next = 1'b0;
                    acc_pos_next   = '0;
                    acc_count_next = '0;
                    state_next     = ST_RUN;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (proc_valid_reg && !proc_sweep_reg)
        begin
            acc_flag_next  = flag_acc_new;
            acc_found_next = found_new;
            acc_pos_next   = pos_new;
            acc_count_next = count_new;
            if (proc_last_reg)
            begin
                done_next  = 1'b1;
                error_next = (act_reg == ACT_SET || act_reg == ACT_TEST) && !idx_ok;
                case (act_reg)
                    ACT_TEST, ACT_EQUAL, ACT_INTERSECTS, ACT_EMPTY, ACT_FULL:
                    begin
                        flag_next  = flag_acc_new;
                        value_next = '0;
                    end
                    ACT_COUNT:
                    begin
                        flag_next  = 1'b0;
                        value_next = count_new[VALUE_W-1:0];
                    end
                    ACT_FIRST:
                    begin
                        flag_next  = found_new;
                        value_next = found_new ? pos_new[VALUE_W-1:0] : cur_len[VALUE_W-1:0];
                    end
                    ACT_NEXT:
                    begin
                        flag_next  = found_new;
                        value_next = found_new ? pos_new[VALUE_W-1:0] : idx_ext[VALUE_W-1:0];
                    end
                    default:
                    begin
                        flag_next  = 1'b0;
                        value_next = '0;
                    end
                endcase
            end
        end

        // a length write restarts the trim pass with the shortest length pending
        if (cfg_we)
        begin
            valid_bits_next = cfg_wdata;
            trim_len_next   = (sweep_active && trim_len_reg < new_len) ? trim_len_reg : new_len;
            state_next      = ST_SWEEP;
            word_cnt_next   = '0;
            sweep_vec_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_SWEEP;
            valid_bits_reg <= VALID_BITS_RESET;
            trim_len_reg   <= '0;
            sweep_vec_reg  <= '0;
            word_cnt_reg   <= '0;
            proc_valid_reg <= 1'b0;
            proc_sweep_reg <= 1'b0;
            proc_last_reg  <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            valid_bits_reg <= valid_bits_next;
            trim_len_reg   <= trim_len_next;
            sweep_vec_reg  <= sweep_vec_next;
            word_cnt_reg   <= word_cnt_next;
            proc_valid_reg <= proc_valid_next;
            proc_sweep_reg <= proc_sweep_next;
            proc_last_reg  <= proc_last_next;
            done_reg       <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg       <= act_next;
        idx_reg       <= idx_next;
        a_vec_reg     <= a_vec_next;
        b_vec_reg     <= b_vec_next;
        proc_word_reg <= proc_word_next;
        proc_addr_reg <= proc_addr_next;
        acc_flag_reg  <= acc_flag_next;
        acc_found_reg <= acc_found_next;
        acc_pos_reg   <= acc_pos_next;
        acc_count_reg <= acc_count_next;
        flag_reg      <= flag_next;
        value_reg     <= value_next;
        error_reg     <= error_next;
    end

endmodule

// ----- rtl/core/bsoe_ram.sv -----
// generic simple memory: one write port, two registered read ports
// depends on bsoe_pkg for the default word width

module bsoe_ram #(
    parameter int WIDTH = bsoe_pkg::WORD_W,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    output logic [WIDTH-1:0]         rdata_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

// ----- rtl/core/bsoe_checker.sv -----
// port-level checks for the bit set operation engine, bound to the top level
// depends on bsoe_pkg and bit_set_operation_engine

module bsoe_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         start,
    input logic                         busy,
    input logic                         cfg_we,
    input logic                         done,
    input logic                         flag,
    input logic [bsoe_pkg::VALUE_W-1:0] value,
    input logic                         error
);

    // an accepted command keeps the engine busy in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("command transfer not followed by busy");

    // a length write starts the trim pass
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> busy)
        else $error("length write not followed by busy");

    // a result ends a busy period
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result without a preceding busy period");

    // results are single-cycle strobes
    assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("back-to-back result strobes");

    // a range error carries no answer
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && error) |-> (!flag && value == '0))
        else $error("range error with nonzero flag or value");

endmodule

bind bit_set_operation_engine bsoe_checker u_bsoe_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .cfg_we (cfg_we),
    .done   (done),
    .flag   (flag),
    .value  (value),
    .error  (error)
);
